### src/olst_pkg.sv
// ----------------------------------------------------------------------------
// olst_pkg: shared types and constants of the ordered list store
// Holds the word formats of both channels, the request codes and the command
// structures that the control logic broadcasts to the row of storage cells.
// ----------------------------------------------------------------------------
package olst_pkg;

  // Number of entries the store can hold.
  localparam int CAPACITY = 32;
  // Bits needed to address one cell.
  localparam int IDX_W    = $clog2(CAPACITY);
  // Bits needed to hold a count from zero up to CAPACITY.
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths of the channel words.
  localparam int FUNC_W   = 4;
  localparam int POS_W    = 6;
  localparam int DATA_W   = 32;
  localparam int ECNT_W   = 6;

  // Request codes.
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 4'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 4'd1;
  localparam logic [FUNC_W-1:0] FN_INSERT_AT  = 4'd2;
  localparam logic [FUNC_W-1:0] FN_GET_BACK   = 4'd3;
  localparam logic [FUNC_W-1:0] FN_GET_FRONT  = 4'd4;
  localparam logic [FUNC_W-1:0] FN_GET_AT     = 4'd5;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 4'd6;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 4'd7;
  localparam logic [FUNC_W-1:0] FN_REMOVE_VAL = 4'd8;

  // Input word.
  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } olst_in_t;

  // Output word.
  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic [ECNT_W-1:0]        entry_count;
    logic                     is_empty;
  } olst_out_t;

  // Update applied to every cell in the same cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

  // Lookup broadcast: compare against a key and mark the addressed cell.
  typedef struct packed {
    logic              en;
    logic [DATA_W-1:0] key;
    logic [IDX_W-1:0]  sel;
    logic [CNT_W-1:0]  cnt;
  } cell_probe_t;

endpackage

### src/olst_cell.sv
// ----------------------------------------------------------------------------
// olst_cell: one storage cell of the ordered list store
// Holds one entry, shifts it to or from its neighbours on insert and delete,
// and flags a key match and a read select during the lookup cycle.
// ----------------------------------------------------------------------------
module olst_cell (
  input  logic                       clk_i,
  input  logic [olst_pkg::IDX_W-1:0] idx_i,
  input  olst_pkg::cell_cmd_t        cmd_i,
  input  olst_pkg::cell_probe_t      probe_i,
  input  logic [olst_pkg::DATA_W-1:0] left_i,
  input  logic [olst_pkg::DATA_W-1:0] right_i,
  output logic [olst_pkg::DATA_W-1:0] value_o,
  output logic                       match_o,
  output logic [olst_pkg::DATA_W-1:0] read_o
);

  import olst_pkg::*;

  logic [DATA_W-1:0] value_q, value_d;
  logic              match_q;
  logic              hit_q;

  // Next entry: make room above the insert point, close the gap on delete.
  always_comb begin
    value_d = value_q;
    case (cmd_i.op)
      CELL_INSERT: begin
        if (idx_i == cmd_i.pos) begin
          value_d = cmd_i.value;
        end else if (idx_i > cmd_i.pos) begin
          value_d = left_i;
        end
      end
      CELL_DELETE: begin
        if (idx_i >= cmd_i.pos) begin
          value_d = right_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  // Lookup flags, taken in the lookup state, before the update.
  always_ff @(posedge clk_i) begin
    if (probe_i.en) begin
      match_q <= (value_q == probe_i.key) && (CNT_W'(idx_i) < probe_i.cnt);
      hit_q   <= (idx_i == probe_i.sel);
    end
  end

  assign value_o = value_q;
  assign match_o = match_q;
  assign read_o  = hit_q ? value_q : '0;

endmodule

### src/ordered_list_store.sv
// ----------------------------------------------------------------------------
// ordered_list_store: bounded ordered list of signed 32-bit words
// A row of cells holds the entries in position order; a request is looked up
// in the lookup state and applied to all cells at once in the update state.
// The result word is registered after the lookup and update states, and the
// update waits while a previous result has not been taken by out_ready_i.
// A new request is taken only in the idle state, after the last one is done.
// Reset: the entry count clears to zero; entry contents are left as they are.
// ----------------------------------------------------------------------------
module ordered_list_store (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  olst_pkg::olst_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output olst_pkg::olst_out_t  out_data_o
);

  import olst_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  olst_in_t          req_q;
  olst_out_t         out_q, res_d;
  logic              out_valid_q;
  logic              exec_go;

  cell_cmd_t         cmd_d, cell_cmd;
  cell_probe_t       probe;
  logic [DATA_W-1:0] cell_val [CAPACITY];
  logic [DATA_W-1:0] cell_rd  [CAPACITY];
  logic [CAPACITY-1:0] match;
  logic [DATA_W-1:0] rd_word;
  logic              found;
  logic [IDX_W-1:0]  found_idx;
  logic              full, empty;

  assign in_ready_o = (state_q == ST_IDLE);
  assign exec_go    = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);
  assign full       = (cnt_q == CNT_W'(CAPACITY));
  assign empty      = (cnt_q == '0);

  // Sequencer: take, look up, update.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_LOOK;
      ST_LOOK: state_d = ST_EXEC;
      ST_EXEC: if (exec_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_go) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result words.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_data_i;
    end
    if (exec_go) begin
      out_q <= res_d;
    end
  end

  // Lookup broadcast: the read address depends on the request kind.
  always_comb begin
    probe.en  = (state_q == ST_LOOK);
    probe.key = req_q.value;
    probe.cnt = cnt_q;
    case (req_q.func)
      FN_GET_BACK, FN_POP_BACK: probe.sel = IDX_W'(cnt_q - CNT_W'(1));
      FN_GET_AT:                probe.sel = IDX_W'(req_q.position);
      default:                  probe.sel = '0;
    endcase
  end

  // Row of cells, each fed by its neighbours.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner_r
      assign right_w = cell_val[g+1];
    end
    olst_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(g)),
      .cmd_i   (cell_cmd),
      .probe_i (probe),
      .left_i  (left_w),
      .right_i (right_w),
      .value_o (cell_val[g]),
      .match_o (match[g]),
      .read_o  (cell_rd[g])
    );
  end

  // Gather the selected word and the frontmost match.
  always_comb begin
    rd_word   = '0;
    found     = 1'b0;
    found_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        found     = 1'b1;
        found_idx = IDX_W'(i);
      end
    end
  end

  // Decide the outcome and the cell update.
  always_comb begin
    logic ok;
    logic [DATA_W-1:0] rd;
    ok        = 1'b0;
    rd        = '0;
    cnt_d     = cnt_q;
    cmd_d.op    = CELL_HOLD;
    cmd_d.pos   = '0;
    cmd_d.value = req_q.value;
    case (req_q.func)
      FN_PUSH_BACK: begin
        if (!full) begin
          ok        = 1'b1;
          cmd_d.op  = CELL_INSERT;
          cmd_d.pos = IDX_W'(cnt_q);
        end
      end
      FN_PUSH_FRONT: begin
        if (!full) begin
          ok       = 1'b1;
          cmd_d.op = CELL_INSERT;
        end
      end
      FN_INSERT_AT: begin
        if (!full && (32'(req_q.position) <= 32'(cnt_q))) begin
          ok        = 1'b1;
          cmd_d.op  = CELL_INSERT;
          cmd_d.pos = IDX_W'(req_q.position);
        end
      end
      FN_GET_BACK, FN_GET_FRONT: begin
        if (!empty) begin
          ok = 1'b1;
          rd = rd_word;
        end
      end
      FN_GET_AT: begin
        if (32'(req_q.position) < 32'(cnt_q)) begin
          ok = 1'b1;
          rd = rd_word;
        end
      end
      FN_POP_BACK: begin
        if (!empty) begin
          ok        = 1'b1;
          rd        = rd_word;
          cmd_d.op  = CELL_DELETE;
          cmd_d.pos = IDX_W'(cnt_q - CNT_W'(1));
        end
      end
      FN_POP_FRONT: begin
        if (!empty) begin
          ok       = 1'b1;
          rd       = rd_word;
          cmd_d.op = CELL_DELETE;
        end
      end
      FN_REMOVE_VAL: begin
        if (found) begin
          ok        = 1'b1;
          cmd_d.op  = CELL_DELETE;
          cmd_d.pos = found_idx;
        end
      end
      default: ok = 1'b0;
    endcase
    if (cmd_d.op == CELL_INSERT) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_d.op == CELL_DELETE) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
    res_d.ok          = ok;
    res_d.read_value  = rd;
    res_d.entry_count = ECNT_W'(cnt_d);
    res_d.is_empty    = (cnt_d == '0);
  end

  // The cells only move when the result is committed.
  always_comb begin
    cell_cmd = cmd_d;
    if (!exec_go) begin
      cell_cmd.op = CELL_HOLD;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
